@@ design/lca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

    // Field widths of the item and result words
    localparam int IDX_W   = 10;
    localparam int DEPTH_W = 11;

    // Table depth follows from the node index width
    localparam int TABLE_DEPTH = 1 << IDX_W;

    // Default step budget of one climb
    localparam int NODES_DEFAULT = 1024;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One table entry: parent link and depth of a node
    typedef struct packed {
        logic [IDX_W-1:0]   parent;
        logic [DEPTH_W-1:0] depth;
    } node_entry_t;

    // Sequencer states: idle, raise first node, raise second node, joint climb
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAISE_A,
        ST_RAISE_B,
        ST_JOINT
    } lca_state_t;

endpackage

`default_nettype wire

@@ design/lca_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lca_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [lca_pkg::IDX_W-1:0]      node_a;
    logic [lca_pkg::IDX_W-1:0]      node_b;
    logic [lca_pkg::IDX_W-1:0]      parent_in;
    logic [lca_pkg::DEPTH_W-1:0]    depth_in;

    modport source (output valid, kind, node_a, node_b, parent_in, depth_in, input ready);
    modport sink   (input valid, kind, node_a, node_b, parent_in, depth_in, output ready);
endinterface

`default_nettype wire

@@ design/lca_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lca_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lca_pkg::IDX_W-1:0]  ancestor;
    logic                       fault;

    modport source (output valid, ancestor, fault, input ready);
    modport sink   (input valid, ancestor, fault, output ready);
endinterface

`default_nettype wire

@@ design/lca_parent_climb_engine.sv @@
// Lowest common ancestor engine over a loaded parent/depth table.
// req channel: a load word (kind = load) writes parent_in and depth_in
//   for node_a and gives no result; a query word (kind = query) asks for
//   the lowest common ancestor of node_a and node_b.
// rsp channel: one word per query with ancestor and fault. fault is set,
//   with ancestor = 0, when the climb would need more than NODES steps.
// A query's steps are its parent moves (single moves to equalize depth
//   plus joint moves), at most NODES. Each step is one read of the
//   dual-read-port node table, whose registered read data sets the pace
//   of one step per cycle.
// Throughput: one query at a time; req.ready is high only while no query
//   is climbing; loads are taken every cycle while the block is idle.
// Reset clears the sequencer and the result valid flag; table contents
//   stay undefined until loaded.
// A stalled receiver holds the result in the output register; the next
//   query may start and its climb waits with its answer until the
//   register frees.
`timescale 1ns / 1ps
`default_nettype none

module lca_parent_climb_engine #(
    parameter int NODES = lca_pkg::NODES_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    lca_req_if.sink     req,
    lca_rsp_if.source   rsp
);

    localparam int STEP_W = $clog2(NODES + 1);

    // Node table, two read ports and one write port
    lca_pkg::node_entry_t node_mem [lca_pkg::TABLE_DEPTH];

    lca_pkg::node_entry_t rd_a_reg;
    lca_pkg::node_entry_t rd_b_reg;

    lca_pkg::lca_state_t state_reg, state_next;

    logic [lca_pkg::IDX_W-1:0] a_reg, a_next;
    logic [lca_pkg::IDX_W-1:0] b_reg, b_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;

    logic                      out_valid_reg;
    logic [lca_pkg::IDX_W-1:0] ancestor_reg;
    logic                      fault_reg;

    logic                      wr_en;
    logic                      load_out;
    logic [lca_pkg::IDX_W-1:0] res_ancestor;
    logic                      res_fault;
    logic                      finish;
    logic                      out_free;
    logic                      budget_spent;

    // Write loads, read the nodes the climb moves to
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[req.node_a] <= '{parent: req.parent_in, depth: req.depth_in};
        end
        rd_a_reg <= node_mem[a_next];
        rd_b_reg <= node_mem[b_next];
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Climb position and step count
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        steps_reg <= steps_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ancestor_reg <= res_ancestor;
            fault_reg    <= res_fault;
        end
    end

    assign out_free     = !out_valid_reg || rsp.ready;
    assign budget_spent = steps_reg >= STEP_W'(NODES);

    // Next state, climb step and handshake
    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        steps_next   = steps_reg;
        wr_en        = 1'b0;
        finish       = 1'b0;
        load_out     = 1'b0;
        res_ancestor = a_reg;
        res_fault    = 1'b0;
        req.ready    = 1'b0;

        unique case (state_reg)
            lca_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.kind == lca_pkg::KIND_LOAD)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        a_next     = req.node_a;
                        b_next     = req.node_b;
                        steps_next = '0;
                        state_next = lca_pkg::ST_RAISE_A;
                    end
                end
            end

            lca_pkg::ST_RAISE_A:
            begin
                // Raise the first node while deeper, then move on to the next phase
                priority if (rd_a_reg.depth > rd_b_reg.depth)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        a_next     = rd_a_reg.parent;
                        steps_next = steps_reg + 1'b1;
                    end
                end
                else if (rd_b_reg.depth > rd_a_reg.depth)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        b_next     = rd_b_reg.parent;
                        steps_next = steps_reg + 1'b1;
                        state_next = lca_pkg::ST_RAISE_B;
                    end
                end
                else if (a_reg != b_reg)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        a_next     = rd_a_reg.parent;
                        b_next     = rd_b_reg.parent;
                        steps_next = steps_reg + 1'b1;
                        state_next = lca_pkg::ST_JOINT;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            lca_pkg::ST_RAISE_B:
            begin
                // Raise the second node while deeper, then climb both
                priority if (rd_b_reg.depth > rd_a_reg.depth)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        b_next     = rd_b_reg.parent;
                        steps_next = steps_reg + 1'b1;
                    end
                end
                else if (a_reg != b_reg)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        a_next     = rd_a_reg.parent;
                        b_next     = rd_b_reg.parent;
                        steps_next = steps_reg + 1'b1;
                        state_next = lca_pkg::ST_JOINT;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            lca_pkg::ST_JOINT:
            begin
                // Raise both together until they meet, depths no longer checked
                if (a_reg != b_reg)
                begin
                    if (budget_spent)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        a_next     = rd_a_reg.parent;
                        b_next     = rd_b_reg.parent;
                        steps_next = steps_reg + 1'b1;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = lca_pkg::ST_IDLE;
            end
        endcase

        // Fault answers carry ancestor zero
        if (finish && budget_spent && (a_reg != b_reg))
        begin
            res_fault    = 1'b1;
            res_ancestor = '0;
        end

        // Hold the climb in place while the result register is full
        if (finish && out_free)
        begin
            load_out   = 1'b1;
            state_next = lca_pkg::ST_IDLE;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.ancestor = ancestor_reg;
    assign rsp.fault    = fault_reg;

endmodule

`default_nettype wire

@@ tb/tb_lca_parent_climb_engine.sv @@
`timescale 1ns / 1ps

module tb_lca_parent_climb_engine;

    localparam int IDX_W          = lca_pkg::IDX_W;
    localparam int DEPTH_W        = lca_pkg::DEPTH_W;
    localparam int TABLE_DEPTH    = lca_pkg::TABLE_DEPTH;
    localparam int NODES          = lca_pkg::NODES_DEFAULT;
    localparam int MAX_IDLE       = 13;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int MAX_DEPTH      = 1024;
    localparam int TAIL_CYCLES    = NODES + 4;
    localparam int WATCHDOG_LIMIT = 4 * (NODES + 2 + 2 * MAX_IDLE);
    localparam int DIR_ROWS       = 21;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   node_a;
        logic [IDX_W-1:0]   node_b;
        logic [IDX_W-1:0]   parent_in;
        logic [DEPTH_W-1:0] depth_in;
    } lca_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] ancestor;
        logic             fault;
    } lca_answer_t;

    // One directed row: the word, and a typed answer where known by hand
    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   node_a;
        logic [IDX_W-1:0]   node_b;
        logic [IDX_W-1:0]   parent_in;
        logic [DEPTH_W-1:0] depth_in;
        logic               typed;
        logic [IDX_W-1:0]   ancestor;
        logic               fault;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lca_req_if req ();
    lca_rsp_if rsp ();

    lca_parent_climb_engine #(
        .NODES (NODES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow node tables and the answers still owed by the block
    bit [IDX_W-1:0]   parent_tab [TABLE_DEPTH];
    bit [DEPTH_W-1:0] depth_tab  [TABLE_DEPTH];
    bit               loaded     [TABLE_DEPTH];
    int               loaded_ids [$];
    lca_answer_t      pending_answers [$];

    int failures = 0;
    bit req_steady = 1'b0;
    bit rsp_steady = 1'b0;
    int quiet_cycles = 0;

    dir_row_t directed_rows [DIR_ROWS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Climb parent links as the block does; return 0 if an unloaded entry is read
    function automatic bit predict_ancestor(input bit [IDX_W-1:0] qa,
                                            input bit [IDX_W-1:0] qb,
                                            output lca_answer_t answer);
        bit [IDX_W-1:0] a;
        bit [IDX_W-1:0] b;
        int             steps;
        bit             flt;
        bit             legal;
        a     = qa;
        b     = qb;
        steps = 0;
        flt   = 1'b0;
        legal = loaded[a] && loaded[b];
        // raise the deeper first node
        while (!flt && depth_tab[a] > depth_tab[b])
        begin
            if (steps >= NODES)
                flt = 1'b1;
            else
            begin
                a     = parent_tab[a];
                steps = steps + 1;
                legal = legal && loaded[a];
            end
        end
        // raise the deeper second node
        while (!flt && depth_tab[b] > depth_tab[a])
        begin
            if (steps >= NODES)
                flt = 1'b1;
            else
            begin
                b     = parent_tab[b];
                steps = steps + 1;
                legal = legal && loaded[b];
            end
        end
        // raise both together until they meet
        while (!flt && a != b)
        begin
            if (steps >= NODES)
                flt = 1'b1;
            else
            begin
                legal = legal && loaded[a] && loaded[b];
                a     = parent_tab[a];
                b     = parent_tab[b];
                steps = steps + 1;
            end
        end
        answer.ancestor = flt ? '0 : a;
        answer.fault    = flt;
        return legal;
    endfunction

    // Drive one word after a random gap; hold until taken, then update the shadow
    task automatic send_word(input lca_word_t w, input lca_answer_t answer);
        int gap;
        if ($urandom_range(0, 31) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.kind      <= w.kind;
        req.node_a    <= w.node_a;
        req.node_b    <= w.node_b;
        req.parent_in <= w.parent_in;
        req.depth_in  <= w.depth_in;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (w.kind == lca_pkg::KIND_LOAD)
        begin
            parent_tab[w.node_a] = w.parent_in;
            depth_tab[w.node_a]  = w.depth_in;
            if (!loaded[w.node_a])
            begin
                loaded[w.node_a] = 1'b1;
                loaded_ids.push_back(int'(w.node_a));
            end
        end
        else
            pending_answers.push_back(answer);
    endtask

    // Directed table and random traffic
    initial
    begin
        lca_word_t   w;
        lca_answer_t answer;
        bit          ok;
        int          i;
        int          k;
        int          pick;
        int          sent;
        int          tries;
        int          idx;
        int          tree_target;
        int          tree_nodes [$];
        int          tree_levels [$];
        bit          in_tree [TABLE_DEPTH];
        bit [IDX_W-1:0] id;

        req.valid     <= 1'b0;
        req.kind      <= lca_pkg::KIND_LOAD;
        req.node_a    <= '0;
        req.node_b    <= '0;
        req.parent_in <= '0;
        req.depth_in  <= '0;

        // small tree, self loops, a two-node cycle and a depth of zero
        directed_rows = '{
            '{lca_pkg::KIND_LOAD, 10'd0, 10'd1023, 10'd0, 11'd1, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd1023, 10'd0, 10'd0, 11'd2, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd512, 10'd1023, 10'd0, 11'd2, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd5, 10'd0, 10'd1023, 11'd3, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd6, 10'd0, 10'd5, 11'd4, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd0, 10'd0, 10'd0, 11'd0, 1'b1, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd1023, 10'd1023, 10'd1023, 11'd1024, 1'b1, 10'd1023, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd6, 10'd512, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd512, 10'd6, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd1023, 10'd512, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd6, 10'd1023, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd5, 10'd6, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd100, 10'd0, 10'd100, 11'd1024, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd100, 10'd0, 10'd0, 11'd0, 1'b1, 10'd0, 1'b1},
            '{lca_pkg::KIND_QUERY, 10'd0, 10'd100, 10'd0, 11'd0, 1'b1, 10'd0, 1'b1},
            '{lca_pkg::KIND_LOAD, 10'd200, 10'd0, 10'd201, 11'd7, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_LOAD, 10'd201, 10'd0, 10'd200, 11'd7, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd200, 10'd201, 10'd0, 11'd0, 1'b1, 10'd0, 1'b1},
            '{lca_pkg::KIND_LOAD, 10'd300, 10'd0, 10'd1023, 11'd0, 1'b0, 10'd0, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd300, 10'd300, 10'd0, 11'd0, 1'b1, 10'd300, 1'b0},
            '{lca_pkg::KIND_QUERY, 10'd300, 10'd6, 10'd0, 11'd0, 1'b0, 10'd0, 1'b0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            w.kind      = directed_rows[i].kind;
            w.node_a    = directed_rows[i].node_a;
            w.node_b    = directed_rows[i].node_b;
            w.parent_in = directed_rows[i].parent_in;
            w.depth_in  = directed_rows[i].depth_in;
            if (directed_rows[i].typed)
            begin
                answer.ancestor = directed_rows[i].ancestor;
                answer.fault    = directed_rows[i].fault;
            end
            else
                ok = predict_ancestor(w.node_a, w.node_b, answer);
            send_word(w, answer);
        end

        // random part: mostly well-formed trees, some noise loads and loose queries
        sent  = 0;
        tries = 0;
        for (k = 0; k < TABLE_DEPTH; k++)
            in_tree[k] = 1'b0;
        tree_target = 0;
        while (sent < RANDOM_ITEMS && tries < 50 * RANDOM_ITEMS)
        begin
            tries       = tries + 1;
            pick        = $urandom_range(0, 99);
            ok          = 1'b1;
            answer      = '0;
            w.node_b    = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            w.parent_in = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            w.depth_in  = DEPTH_W'($urandom_range(0, MAX_DEPTH));
            if (tree_nodes.size() == 0)
            begin
                // start a new tree at a random root
                tree_target = $urandom_range(2, 80);
                w.kind      = lca_pkg::KIND_LOAD;
                w.node_a    = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                w.depth_in  = 11'd1;
                tree_nodes.push_back(int'(w.node_a));
                tree_levels.push_back(1);
                in_tree[w.node_a] = 1'b1;
            end
            else if (pick < 40 && tree_nodes.size() < tree_target)
            begin
                // hang a fresh node under a recent or random tree node
                if ($urandom_range(0, 9) < 6)
                    idx = tree_nodes.size() - 1;
                else
                    idx = $urandom_range(0, tree_nodes.size() - 1);
                id = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                for (k = 0; k < 8 && in_tree[id]; k++)
                    id = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                if (in_tree[id])
                    ok = 1'b0;
                else
                begin
                    w.kind      = lca_pkg::KIND_LOAD;
                    w.node_a    = id;
                    w.parent_in = IDX_W'(tree_nodes[idx]);
                    w.depth_in  = DEPTH_W'((tree_levels[idx] < MAX_DEPTH) ?
                                           tree_levels[idx] + 1 : MAX_DEPTH);
                    tree_nodes.push_back(int'(id));
                    tree_levels.push_back(int'(w.depth_in));
                    in_tree[id] = 1'b1;
                end
            end
            else if (pick < 48)
            begin
                // noise load: odd depths, links mostly into loaded nodes
                w.kind   = lca_pkg::KIND_LOAD;
                w.node_a = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                if ($urandom_range(0, 7) != 0 && loaded_ids.size() > 0)
                    w.parent_in = IDX_W'(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]);
                case ($urandom_range(0, 3))
                    0: w.depth_in = '0;
                    1: w.depth_in = DEPTH_W'(MAX_DEPTH);
                    default: ;
                endcase
            end
            else if (pick < 56)
            begin
                // loose query across any loaded nodes
                w.kind   = lca_pkg::KIND_QUERY;
                w.node_a = IDX_W'(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]);
                w.node_b = IDX_W'(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]);
                ok       = predict_ancestor(w.node_a, w.node_b, answer);
            end
            else if (pick < 59)
            begin
                // drop the current tree; next word starts another
                ok = 1'b0;
                foreach (tree_nodes[k])
                    in_tree[tree_nodes[k]] = 1'b0;
                tree_nodes.delete();
                tree_levels.delete();
            end
            else
            begin
                // query inside the current tree
                w.kind   = lca_pkg::KIND_QUERY;
                w.node_a = IDX_W'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
                if ($urandom_range(0, 9) == 0)
                    w.node_b = w.node_a;
                else
                    w.node_b = IDX_W'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
                ok = predict_ancestor(w.node_a, w.node_b, answer);
            end
            if (ok)
            begin
                send_word(w, answer);
                sent = sent + 1;
            end
        end
        req.valid <= 1'b0;

        // drain outstanding answers, then watch for stray words
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Take result words after random stalls and compare with the oldest answer
    initial
    begin
        int          stall;
        lca_answer_t want;
        rsp.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            if (pending_answers.size() == 0)
            begin
                $error("result word with no query pending: ancestor %0d fault %0d",
                       rsp.ancestor, rsp.fault);
                failures = failures + 1;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.ancestor !== want.ancestor)
                begin
                    $error("ancestor: expected %0d, got %0d", want.ancestor, rsp.ancestor);
                    failures = failures + 1;
                end
                if (rsp.fault !== want.fault)
                begin
                    $error("fault: expected %0d, got %0d", want.fault, rsp.fault);
                    failures = failures + 1;
                end
            end
        end
    end

    // Stop the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
